// ===== hw/rtl/lom_pkg.sv =====
// ============================================================================
// lom_pkg
// Shared types and constants for the limit order matcher.
// ============================================================================
package lom_pkg;

    localparam int ORDER_SLOTS = 32;
    localparam int SLOT_W      = $clog2(ORDER_SLOTS);
    localparam int CNT_W       = $clog2(ORDER_SLOTS + 1);
    localparam int ID_W        = 32;
    localparam int PRICE_W     = 20;
    localparam int QTY_W       = 24;
    localparam int STAMP_W     = 32;
    localparam int ENTRY_W     = 1 + ID_W + PRICE_W + QTY_W + STAMP_W;

    localparam logic [1:0] OP_NEW    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;

    localparam logic [2:0] KIND_FILL      = 3'd0;
    localparam logic [2:0] KIND_RESTED    = 3'd1;
    localparam logic [2:0] KIND_FILLED    = 3'd2;
    localparam logic [2:0] KIND_CANCELLED = 3'd3;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd4;
    localparam logic [2:0] KIND_BOOK_FULL = 3'd5;

    typedef struct packed {
        logic               side;
        logic [ID_W-1:0]    id;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_FIND_CHK,
        ST_SCAN,
        ST_SCAN_CHK,
        ST_HIT_RD,
        ST_HIT_WR,
        ST_STATUS,
        ST_OUT
    } state_t;

endpackage

// ===== hw/rtl/limit_order_matcher.sv =====
// ============================================================================
// limit_order_matcher
// Price-time priority limit order book over a table of resting orders.
// ============================================================================
// One request at a time. Orders sit in one slot RAM (registered read); slot
// valid bits are flip-flops. Every search walks the RAM one slot per cycle,
// so a cancel walks it until the order is found, and a new order walks it
// once per fill and once more if quantity remains after its fills. Each
// result waits in the output register until taken. No clearing pass is
// needed after reset.
module limit_order_matcher
    import lom_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[1:0], order_id[33:2], side[34], price[54:35], quantity[78:55]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // kind[2:0], fill_side[3], fill_price[23:4], fill_qty[47:24],
    // remaining_qty[71:48]
    output logic [71:0] m_tdata,
    output logic        m_tlast
);

    state_t state_reg, state_next;

    logic [ORDER_SLOTS-1:0] valid_reg, valid_next;
    logic [STAMP_W-1:0]     arrival_reg, arrival_next;

    logic [1:0]         op_reg, op_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic               side_reg, side_next;
    logic [PRICE_W-1:0] price_reg, price_next;
    logic [QTY_W-1:0]   qty_reg, qty_next;

    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [SLOT_W-1:0]  chk_reg, chk_next;
    logic               chk_v_reg, chk_v_next;
    logic               found_reg, found_next;
    logic [SLOT_W-1:0]  best_reg, best_next;
    logic [PRICE_W-1:0] bprice_reg, bprice_next;
    logic [STAMP_W-1:0] bstamp_reg, bstamp_next;

    logic [71:0] out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;

    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
    entry_t             ram_wdata, ram_rdata;

    lom_ram #(.WIDTH(ENTRY_W), .DEPTH(ORDER_SLOTS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic              free_any;
    logic [SLOT_W-1:0] free_idx;
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    logic crosses, better;
    logic [QTY_W-1:0] trade;
    always_comb begin
        crosses = valid_reg[chk_reg] && (ram_rdata.side != side_reg) &&
                  (side_reg ? (ram_rdata.price >= price_reg)
                            : (ram_rdata.price <= price_reg));
        if (!found_reg) begin
            better = 1'b1;
        end else if (ram_rdata.price == bprice_reg) begin
            better = ram_rdata.stamp < bstamp_reg;
        end else begin
            better = side_reg ? (ram_rdata.price > bprice_reg)
                              : (ram_rdata.price < bprice_reg);
        end
        trade = (qty_reg < ram_rdata.qty) ? qty_reg : ram_rdata.qty;
    end

    logic scan_end;
    assign scan_end = (idx_reg == CNT_W'(ORDER_SLOTS));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (s_tdata[1:0])
                        OP_NEW:    state_next = ST_SCAN;
                        OP_CANCEL: state_next = ST_FIND;
                        OP_MODIFY: state_next = ST_FIND;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FIND:     state_next = ST_FIND_CHK;
            ST_FIND_CHK: begin
                if (valid_reg[chk_reg] && ram_rdata.id == id_reg) begin
                    state_next = (op_reg == OP_CANCEL) ? ST_OUT : ST_SCAN;
                end else if (scan_end) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_FIND_CHK;
                end
            end
            ST_SCAN:     state_next = (qty_reg == '0) ? ST_STATUS : ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (scan_end) begin
                    state_next = (found_reg || (crosses && better)) ? ST_HIT_RD
                                                                     : ST_STATUS;
                end
            end
            ST_HIT_RD:   state_next = ST_HIT_WR;
            ST_HIT_WR:   state_next = ST_OUT;
            ST_STATUS:   state_next = ST_OUT;
            ST_OUT: begin
                if (m_tready) begin
                    state_next = out_last_reg ? ST_IDLE : ST_SCAN;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        valid_next    = valid_reg;
        arrival_next  = arrival_reg;
        op_next       = op_reg;
        id_next       = id_reg;
        side_next     = side_reg;
        price_next    = price_reg;
        qty_next      = qty_reg;
        idx_next      = idx_reg;
        chk_next      = chk_reg;
        chk_v_next    = 1'b0;
        found_next    = found_reg;
        best_next     = best_reg;
        bprice_next   = bprice_reg;
        bstamp_next   = bstamp_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        ram_we        = 1'b0;
        ram_waddr     = best_reg;
        ram_wdata     = ram_rdata;
        ram_raddr     = idx_reg[SLOT_W-1:0];
        case (state_reg)
            ST_IDLE: begin
                op_next    = s_tdata[1:0];
                id_next    = s_tdata[33:2];
                side_next  = s_tdata[34];
                price_next = s_tdata[54:35];
                qty_next   = s_tdata[78:55];
                idx_next   = '0;
            end
            ST_FIND: begin
                ram_raddr = '0;
                chk_next  = '0;
                idx_next  = CNT_W'(1);
            end
            ST_FIND_CHK: begin
                if (valid_reg[chk_reg] && ram_rdata.id == id_reg) begin
                    valid_next[chk_reg] = 1'b0;
                    side_next           = ram_rdata.side;
                    out_data_next = {ram_rdata.qty, {QTY_W{1'b0}}, {PRICE_W{1'b0}},
                                     ram_rdata.side, KIND_CANCELLED};
                    out_last_next = 1'b1;
                end else if (scan_end) begin
                    out_data_next = {{QTY_W{1'b0}}, {QTY_W{1'b0}}, {PRICE_W{1'b0}},
                                     1'b0, KIND_NOT_FOUND};
                    out_last_next = 1'b1;
                end else begin
                    ram_raddr = idx_reg[SLOT_W-1:0];
                    chk_next  = idx_reg[SLOT_W-1:0];
                    idx_next  = idx_reg + CNT_W'(1);
                end
            end
            ST_SCAN: begin
                ram_raddr  = '0;
                chk_next   = '0;
                idx_next   = CNT_W'(1);
                found_next = 1'b0;
            end
            ST_SCAN_CHK: begin
                if (crosses && better) begin
                    found_next  = 1'b1;
                    best_next   = chk_reg;
                    bprice_next = ram_rdata.price;
                    bstamp_next = ram_rdata.stamp;
                end
                if (!scan_end) begin
                    ram_raddr = idx_reg[SLOT_W-1:0];
                    chk_next  = idx_reg[SLOT_W-1:0];
                    idx_next  = idx_reg + CNT_W'(1);
                end
            end
            ST_HIT_RD: begin
                ram_raddr = best_reg;
            end
            ST_HIT_WR: begin
                ram_we        = 1'b1;
                ram_waddr     = best_reg;
                ram_wdata     = ram_rdata;
                ram_wdata.qty = ram_rdata.qty - trade;
                if (ram_rdata.qty == trade) begin
                    valid_next[best_reg] = 1'b0;
                end
                qty_next      = qty_reg - trade;
                out_data_next = {qty_reg - trade, trade, ram_rdata.price,
                                 side_reg, KIND_FILL};
                out_last_next = 1'b0;
            end
            ST_STATUS: begin
                out_last_next = 1'b1;
                if (qty_reg == '0) begin
                    out_data_next = {{QTY_W{1'b0}}, {QTY_W{1'b0}}, {PRICE_W{1'b0}},
                                     side_reg, KIND_FILLED};
                end else if (!free_any) begin
                    out_data_next = {qty_reg, {QTY_W{1'b0}}, {PRICE_W{1'b0}},
                                     side_reg, KIND_BOOK_FULL};
                end else begin
                    ram_we               = 1'b1;
                    ram_waddr            = free_idx;
                    ram_wdata            = '{side: side_reg, id: id_reg,
                                             price: price_reg, qty: qty_reg,
                                             stamp: arrival_reg};
                    valid_next[free_idx] = 1'b1;
                    arrival_next         = arrival_reg + STAMP_W'(1);
                    out_data_next = {qty_reg, {QTY_W{1'b0}}, {PRICE_W{1'b0}},
                                     side_reg, KIND_RESTED};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            arrival_reg <= '0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            arrival_reg <= arrival_next;
        end
        op_reg       <= op_next;
        id_reg       <= id_next;
        side_reg     <= side_next;
        price_reg    <= price_next;
        qty_reg      <= qty_next;
        idx_reg      <= idx_next;
        chk_reg      <= chk_next;
        chk_v_reg    <= chk_v_next;
        found_reg    <= found_next;
        best_reg     <= best_next;
        bprice_reg   <= bprice_next;
        bstamp_reg   <= bstamp_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE) && !chk_v_reg;
        m_tvalid = (state_reg == ST_OUT);
        m_tdata  = out_data_reg;
        m_tlast  = out_last_reg;
    end

endmodule

// ===== hw/rtl/lom_ram.sv =====
// ============================================================================
// lom_ram
// Single-port-write, single-read synchronous RAM with registered read.
// ============================================================================
module lom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/lom_checker.sv =====
// ============================================================================
// lom_checker
// Port-level checks of the limit order matcher.
// ============================================================================
module lom_checker
    import lom_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [79:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("request taken while a result is pending");

    a_fill_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == KIND_FILL |-> !m_tlast)
        else $error("fill marked last");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != KIND_FILL |-> m_tlast)
        else $error("status result not last");

endmodule

bind limit_order_matcher lom_checker u_lom_checker (.*);

// ===== bench/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for the limit order matcher: a model of the book
// predicts fills and status per request, and each result is checked in order.
// ============================================================================
module tb_top;
    import lom_pkg::*;

    typedef struct packed {
        logic [2:0]         kind;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   fqty;
        logic [QTY_W-1:0]   rem;
        logic               last;
    } result_t;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         EXP_DEPTH = 64;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;

    limit_order_matcher u_top (.*);

    always #2 aclk = ~aclk;

    // book model
    logic               bk_valid [ORDER_SLOTS];
    logic               bk_side  [ORDER_SLOTS];
    logic [ID_W-1:0]    bk_id    [ORDER_SLOTS];
    logic [PRICE_W-1:0] bk_price [ORDER_SLOTS];
    logic [QTY_W-1:0]   bk_qty   [ORDER_SLOTS];
    logic [31:0]        bk_stamp [ORDER_SLOTS];
    logic [31:0]        arrivals;

    // expected results, ring buffer
    result_t     exp_mem [EXP_DEPTH];
    int          exp_wr = 0;
    int          exp_rd = 0;
    int          exp_count = 0;

    int          errors = 0;
    int          n_results = 0;
    int          n_fills = 0;
    int          n_requests = 0;
    bit          idle_on = 1'b1;
    int unsigned stall_left = 0;
    int unsigned watchdog = 0;
    bit          done = 1'b0;

    task automatic report_mismatch(input string what, input logic [79:0] got,
                                   input logic [79:0] want);
        errors++;
        $display("MISMATCH %s: got %0h want %0h at result %0d", what, got, want,
                 n_results);
    endtask

    function automatic void push_result(input logic [2:0] k, input logic sd,
                                        input logic [PRICE_W-1:0] p,
                                        input logic [QTY_W-1:0] fq,
                                        input logic [QTY_W-1:0] r,
                                        input logic l);
        result_t x;
        x.kind = k; x.side = sd; x.price = p; x.fqty = fq; x.rem = r; x.last = l;
        if (exp_count == EXP_DEPTH) begin
            errors++;
            $display("MISMATCH expected result buffer overflow");
        end else begin
            exp_mem[exp_wr] = x;
            exp_wr = (exp_wr + 1) % EXP_DEPTH;
            exp_count++;
        end
    endfunction

    function automatic int best_opposite(input logic sd, input logic [PRICE_W-1:0] p);
        int b;
        b = -1;
        for (int i = 0; i < ORDER_SLOTS; i++) begin
            if (!bk_valid[i] || bk_side[i] == sd) continue;
            if (sd == 1'b0 ? bk_price[i] > p : bk_price[i] < p) continue;
            if (b < 0) b = i;
            else if (bk_price[i] == bk_price[b]) begin
                if (bk_stamp[i] < bk_stamp[b]) b = i;
            end else if (sd == 1'b0 ? bk_price[i] < bk_price[b]
                                    : bk_price[i] > bk_price[b]) begin
                b = i;
            end
        end
        return b;
    endfunction

    function automatic void match_order(input logic [ID_W-1:0] id, input logic sd,
                                        input logic [PRICE_W-1:0] p,
                                        input logic [QTY_W-1:0] q);
        int b;
        int f;
        logic [QTY_W-1:0] t;
        while (q != 0) begin
            b = best_opposite(sd, p);
            if (b < 0) break;
            t = (q < bk_qty[b]) ? q : bk_qty[b];
            q -= t;
            bk_qty[b] -= t;
            if (bk_qty[b] == 0) bk_valid[b] = 1'b0;
            push_result(KIND_FILL, sd, bk_price[b], t, q, 1'b0);
        end
        if (q == 0) begin
            push_result(KIND_FILLED, sd, '0, '0, '0, 1'b1);
            return;
        end
        f = -1;
        for (int i = ORDER_SLOTS - 1; i >= 0; i--)
            if (!bk_valid[i]) f = i;
        if (f < 0) begin
            push_result(KIND_BOOK_FULL, sd, '0, '0, q, 1'b1);
            return;
        end
        bk_valid[f] = 1'b1; bk_side[f] = sd; bk_id[f] = id;
        bk_price[f] = p; bk_qty[f] = q; bk_stamp[f] = arrivals;
        arrivals++;
        push_result(KIND_RESTED, sd, '0, '0, q, 1'b1);
    endfunction

    function automatic void predict_request(input logic [79:0] d);
        logic [1:0] op;
        logic [ID_W-1:0] id;
        int s;
        op = d[1:0];
        id = d[33:2];
        if (op == OP_NEW) begin
            match_order(id, d[34], d[54:35], d[78:55]);
            return;
        end
        if (op != OP_CANCEL && op != OP_MODIFY) return;
        s = -1;
        for (int i = ORDER_SLOTS - 1; i >= 0; i--)
            if (bk_valid[i] && bk_id[i] == id) s = i;
        if (s < 0) begin
            push_result(KIND_NOT_FOUND, 1'b0, '0, '0, '0, 1'b1);
            return;
        end
        bk_valid[s] = 1'b0;
        if (op == OP_CANCEL) push_result(KIND_CANCELLED, bk_side[s], '0, '0, bk_qty[s], 1'b1);
        else match_order(id, bk_side[s], d[54:35], d[78:55]);
    endfunction

    // result side: random stalls, checking
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                result_t w;
                n_results++;
                if (exp_count == 0) begin
                    report_mismatch("unexpected result", 80'({m_tlast, m_tdata}), '0);
                end else begin
                    w = exp_mem[exp_rd];
                    exp_rd = (exp_rd + 1) % EXP_DEPTH;
                    exp_count--;
                    if (w.kind == KIND_FILL) n_fills++;
                    if (m_tdata[2:0] != w.kind)
                        report_mismatch("kind", 80'(m_tdata[2:0]), 80'(w.kind));
                    if (m_tdata[3] != w.side)
                        report_mismatch("fill_side", 80'(m_tdata[3]), 80'(w.side));
                    if (m_tdata[23:4] != w.price)
                        report_mismatch("fill_price", 80'(m_tdata[23:4]), 80'(w.price));
                    if (m_tdata[47:24] != w.fqty)
                        report_mismatch("fill_qty", 80'(m_tdata[47:24]), 80'(w.fqty));
                    if (m_tdata[71:48] != w.rem)
                        report_mismatch("remaining_qty", 80'(m_tdata[71:48]), 80'(w.rem));
                    if (m_tlast != w.last)
                        report_mismatch("last", 80'(m_tlast), 80'(w.last));
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 14);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) watchdog = 0;
        else watchdog++;
        if (watchdog > 20000 && !done) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [31:0] id,
                                input logic sd, input logic [19:0] p,
                                input logic [23:0] q);
        logic [79:0] d;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        d = {1'b0, q, p, sd, id, op};
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_request(d);
        n_requests++;
    endtask

    task automatic drain_book();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (exp_count != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_request(OP_CANCEL, 32'hFFFF_FFFF, 1'b0, '0, '0);
        send_request(OP_MODIFY, 32'd0, 1'b1, 20'd5, 24'd5);
        send_request(OP_NEW, 32'd1, 1'b0, 20'd100, 24'd0);
        send_request(OP_NEW, 32'd2, 1'b1, 20'hFFFFF, 24'hFFFFFF);
        send_request(OP_NEW, 32'd3, 1'b1, 20'd100, 24'd10);
        send_request(OP_NEW, 32'd4, 1'b1, 20'd100, 24'd20);
        send_request(OP_NEW, 32'd5, 1'b1, 20'd90, 24'd5);
        send_request(OP_NEW, 32'd5, 1'b1, 20'd90, 24'd7);
        send_request(OP_UNUSED, 32'd5, 1'b0, 20'd1, 24'd1);
        send_request(OP_NEW, 32'd6, 1'b0, 20'd100, 24'd30);
        send_request(OP_MODIFY, 32'd4, 1'b0, 20'd95, 24'd8);
        send_request(OP_NEW, 32'd7, 1'b0, 20'd0, 24'd3);
        send_request(OP_NEW, 32'd8, 1'b1, 20'd0, 24'd100);
        send_request(OP_CANCEL, 32'd2, 1'b0, '0, '0);
        send_request(OP_CANCEL, 32'd2, 1'b0, '0, '0);
        send_request(OP_MODIFY, 32'd8, 1'b1, 20'hFFFFF, 24'd0);
        drain_book();
    endtask

    // fill the book, then overflow it, then sweep it with one large order
    task automatic test_book_full();
        for (int i = 0; i < ORDER_SLOTS + 2; i++)
            send_request(OP_NEW, 32'(100 + i), 1'b1, 20'(500 + (i % 4)), 24'(1 + i));
        send_request(OP_NEW, 32'd999, 1'b0, 20'hFFFFF, 24'hFFFFFF);
        drain_book();
    endtask

    task automatic test_random(input int count);
        logic [1:0] op;
        logic [31:0] id;
        for (int n = 0; n < count; n++) begin
            op = ($urandom_range(0, 9) < 6) ? OP_NEW : 2'($urandom_range(1, 3));
            id = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 47);
            send_request(op, id, 1'($urandom_range(0, 1)),
                         ($urandom_range(0, 15) == 0) ? 20'($urandom)
                                                      : 20'(1000 + $urandom_range(0, 15)),
                         ($urandom_range(0, 15) == 0) ? 24'($urandom)
                                                      : 24'($urandom_range(0, 60)));
            if (n == count / 2) drain_book();
        end
        drain_book();
    endtask

    initial begin
        for (int i = 0; i < ORDER_SLOTS; i++) bk_valid[i] = 1'b0;
        arrivals = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_book_full();
        test_random(300);
        idle_on = 1'b0;
        test_random(110);
        repeat (200) @(posedge aclk);
        done = 1'b1;
        $display("Covered %0d requests, %0d results including %0d fills.",
                 n_requests, n_results, n_fills);
        $display("Book overflow, cancel/modify of unknown ids and zero quantities exercised.");
        if (errors == 0 && exp_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
